### src/greedy_budget_path_builder_core_macros.svh
// Assertion macros used by the path builder core.
`ifndef GREEDY_BUDGET_PATH_BUILDER_CORE_MACROS_SVH
`define GREEDY_BUDGET_PATH_BUILDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBPB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gbpb_pkg.sv
`timescale 1ns / 1ps

package gbpb_pkg;

  localparam int MAX_CITIES = 64;
  localparam int COST_BITS  = 24;
  localparam int CITY_W     = $clog2(MAX_CITIES);
  localparam int ADDR_W     = 2 * CITY_W;
  localparam int DEPTH      = MAX_CITIES * MAX_CITIES;
  localparam int CNT_W      = $clog2(MAX_CITIES + 1);
  localparam int BUDGET_W   = 32;
  localparam int REM_W      = BUDGET_W + 1;
  localparam int SUM_W      = COST_BITS + 1;
  localparam int CMP_W      = REM_W + 1;
  localparam int PICK_CAP   = 62;
  localparam int PICK_W     = $clog2(PICK_CAP + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic FUNC_LOAD      = 1'b0;
  localparam logic FUNC_RUN       = 1'b1;
  localparam logic REG_CITY_COUNT = 1'b0;

  localparam logic [CNT_W-1:0] CITY_COUNT_RESET = CNT_W'(MAX_CITIES);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic run_load;
    logic chk_rd;
    logic scan_clr;
    logic scan_en;
    logic commit;
    logic emit_start;
    logic emit_pick;
    logic emit_end;
    logic busy;
  } gbpb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic cap_hit;
    logic end_ok;
    logic scan_done;
    logic found;
  } gbpb_stat_t;

endpackage

### src/gbpb_in_if.sv
`timescale 1ns / 1ps

interface gbpb_in_if import gbpb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [CITY_W-1:0]          row_city;
  logic [CITY_W-1:0]          col_city;
  logic [COST_BITS-1:0]       cost_value;
  logic [CITY_W-1:0]          origin_city;
  logic [CITY_W-1:0]          goal_city;
  logic signed [BUDGET_W-1:0] budget;

  modport source (
    output valid, func, row_city, col_city, cost_value, origin_city, goal_city, budget,
    input  ready
  );
  modport sink (
    input  valid, func, row_city, col_city, cost_value, origin_city, goal_city, budget,
    output ready
  );
endinterface

### src/gbpb_out_if.sv
`timescale 1ns / 1ps

interface gbpb_out_if import gbpb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CITY_W-1:0] city;
  logic              last;

  modport source (output valid, city, last, input ready);
  modport sink (input valid, city, last, output ready);
endinterface

### src/gbpb_ram.sv
`timescale 1ns / 1ps

module gbpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/gbpb_ctrl.sv
`timescale 1ns / 1ps

module gbpb_ctrl import gbpb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       run_req,
  input  gbpb_stat_t stat,
  output gbpb_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EMIT_S = 3'd1;
  localparam logic [2:0] S_CHK    = 3'd2;
  localparam logic [2:0] S_CHKW   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_EMIT_P = 3'd6;
  localparam logic [2:0] S_EMIT_E = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.busy   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (run_req) begin
          cmd.run_load = 1'b1;
          state_next   = S_EMIT_S;
        end
      end
      S_EMIT_S: begin
        if (stat.slot_free) begin
          cmd.emit_start = 1'b1;
          state_next     = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.cap_hit) begin
          state_next = S_EMIT_E;
        end else begin
          cmd.chk_rd = 1'b1;
          state_next = S_CHKW;
        end
      end
      S_CHKW: begin
        if (stat.end_ok) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end else begin
          state_next = S_EMIT_E;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = stat.found ? S_EMIT_P : S_EMIT_E;
      end
      S_EMIT_P: begin
        if (stat.slot_free) begin
          cmd.emit_pick = 1'b1;
          cmd.commit    = 1'b1;
          state_next    = S_CHK;
        end
      end
      S_EMIT_E: begin
        if (stat.slot_free) begin
          cmd.emit_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/gbpb_dpath.sv
`timescale 1ns / 1ps

module gbpb_dpath import gbpb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  gbpb_cmd_t                  cmd,
  output gbpb_stat_t                 stat,
  input  logic [CNT_W-1:0]           limit,
  input  logic                       load_we,
  input  logic [CITY_W-1:0]          row_city,
  input  logic [CITY_W-1:0]          col_city,
  input  logic [COST_BITS-1:0]       cost_value,
  input  logic [CITY_W-1:0]          origin_city,
  input  logic [CITY_W-1:0]          goal_city,
  input  logic signed [BUDGET_W-1:0] budget,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CITY_W-1:0]          out_city,
  output logic                       out_last
);

  logic [CITY_W-1:0]       cur;
  logic [CITY_W-1:0]       end_c;
  logic signed [REM_W-1:0] rem;
  logic [MAX_CITIES-1:0]   visited;
  logic [PICK_W-1:0]       picks;
  logic [CNT_W-1:0]        idx;
  logic                    pipe_v;
  logic [CITY_W-1:0]       pipe_i;
  logic                    found;
  logic [CITY_W-1:0]       best;
  logic [COST_BITS-1:0]    best_cost;

  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr_a;
  logic [ADDR_W-1:0]       raddr_b;
  logic [COST_BITS-1:0]    a_q;
  logic [COST_BITS-1:0]    b_q;

  logic                    issue;
  logic                    cand_skip;
  logic [SUM_W-1:0]        sum;
  logic signed [CMP_W-1:0] rem_x;
  logic signed [CMP_W-1:0] sum_x;
  logic signed [CMP_W-1:0] a_x;
  logic                    take;

  // Two copies of the cost matrix, so that both costs of a candidate are read together.
  assign waddr   = {row_city, col_city};
  assign raddr_a = cmd.chk_rd ? {cur, end_c} : {cur, idx[CITY_W-1:0]};
  assign raddr_b = {idx[CITY_W-1:0], end_c};

  gbpb_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH)) u_ram_out (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (cost_value),
    .raddr (raddr_a),
    .rdata (a_q)
  );

  gbpb_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH)) u_ram_end (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (cost_value),
    .raddr (raddr_b),
    .rdata (b_q)
  );

  assign issue     = cmd.scan_en && (idx < limit);
  assign cand_skip = (pipe_i == end_c) || visited[pipe_i];
  assign sum       = SUM_W'(a_q) + SUM_W'(b_q);
  assign rem_x     = CMP_W'(rem);
  assign sum_x     = CMP_W'(sum);
  assign a_x       = CMP_W'(a_q);
  assign take      = pipe_v && !cand_skip && (!found || (a_q < best_cost)) &&
                     (rem_x > sum_x);

  assign stat.slot_free = !out_valid || out_ready;
  assign stat.cap_hit   = (picks == PICK_W'(PICK_CAP));
  assign stat.end_ok    = (rem_x >= a_x);
  assign stat.scan_done = !(idx < limit);
  assign stat.found     = found;

  always_ff @(posedge clk) begin
    if (cmd.run_load) begin
      cur     <= origin_city;
      end_c   <= goal_city;
      rem     <= REM_W'(budget);
      visited <= MAX_CITIES'(1) << origin_city;
      picks   <= '0;
    end else if (cmd.commit) begin
      cur           <= best;
      rem           <= rem - REM_W'(best_cost);
      visited[best] <= 1'b1;
      picks         <= picks + PICK_W'(1);
    end

    if (cmd.scan_clr) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + CNT_W'(1);
    end
    pipe_i <= idx[CITY_W-1:0];

    if (take) begin
      best      <= pipe_i;
      best_cost <= a_q;
    end

    if (cmd.emit_start) begin
      out_city <= cur;
    end else if (cmd.emit_pick) begin
      out_city <= best;
    end else if (cmd.emit_end) begin
      out_city <= end_c;
    end
    if (cmd.emit_start || cmd.emit_pick || cmd.emit_end) begin
      out_last <= cmd.emit_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pipe_v <= issue;
      if (cmd.scan_clr) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (cmd.emit_start || cmd.emit_pick || cmd.emit_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/greedy_budget_path_builder_core.sv
`timescale 1ns / 1ps
`include "greedy_budget_path_builder_core_macros.svh"

// Greedy budget path builder. A load item (func = 0) writes one entry of the
// 64 x 64 cost matrix and produces no result; loads stream at one per cycle
// while no run is in progress. A run item (func = 1) builds one path: the
// start city is returned first, then the block repeatedly picks the cheapest
// unvisited city from where it stands that still leaves enough budget to
// reach the end city, and finally returns the end city with last set. Each
// pick round first reads and tests the cost to the end city; then the
// candidate scan walks the cities one per cycle through the registered cost
// memories (two copies of the matrix, one read for the cost out of the
// current city and one for the cost onward to the end city), drains the
// last read, and the block decides and moves on. A stall on the result side
// can hold a run. No new item is taken while a run is in progress. The result
// register lets the block take the next item while its last result still
// waits for a transfer. Cost entries must be written before a run reads them;
// the memories are not cleared at reset. city_count is programmed through the
// APB port at address 0 and reads back there; values above 64 act as 64.
module greedy_budget_path_builder_core import gbpb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  gbpb_in_if.sink               items,
  gbpb_out_if.source            results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  gbpb_cmd_t        cmd;
  gbpb_stat_t       stat;
  logic [CNT_W-1:0] city_count;
  logic [CNT_W-1:0] limit;
  logic             load_we;
  logic             run_req;
  logic [2:0]       emit_vec;

  // Configuration register. The byte-lane bits of the address are ignored.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CITY_COUNT)) begin
      city_count <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CITY_COUNT) begin
      prdata = CFG_DATA_W'(city_count);
    end
  end

  // The scan never looks beyond the matrix, whatever count was programmed.
  assign limit = (city_count > CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES) : city_count;

  // Items are taken only while no run is in progress.
  assign items.ready = !cmd.busy;
  assign load_we     = items.valid && items.ready && (items.func == FUNC_LOAD);
  assign run_req     = items.valid && (items.func == FUNC_RUN);

  gbpb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .run_req (run_req),
    .stat    (stat),
    .cmd     (cmd)
  );

  gbpb_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .limit       (limit),
    .load_we     (load_we),
    .row_city    (items.row_city),
    .col_city    (items.col_city),
    .cost_value  (items.cost_value),
    .origin_city (items.origin_city),
    .goal_city   (items.goal_city),
    .budget      (items.budget),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_city    (results.city),
    .out_last    (results.last)
  );

  // Checks on the controller and the result register.
  assign emit_vec = {cmd.emit_start, cmd.emit_pick, cmd.emit_end};

  `GBPB_ASSERT_SAME(a_emit_onehot, clk, rst, 1'b1, $onehot0(emit_vec), "two results in one cycle")
  `GBPB_ASSERT_SAME(a_emit_slot, clk, rst, emit_vec != 3'b000, !results.valid || results.ready, "result overwritten")
  `GBPB_ASSERT_NEXT(a_end_idle, clk, rst, cmd.emit_end, !cmd.busy, "run not closed after end city")
  `GBPB_ASSERT_NEXT(a_run_busy, clk, rst, cmd.run_load, cmd.busy && !items.ready, "run started but block not busy")

endmodule
